@@ rtl/abpm_pkg.sv @@
// Shared types and constants for the audio block peak meter.
package abpm_pkg;

  localparam int unsigned SampleW = 24;
  localparam int unsigned SlotW   = 32;
  localparam int unsigned LevelW  = 7;
  localparam int unsigned ProdW   = 31;
  localparam int unsigned CfgIdxW = 2;

  localparam logic signed [SampleW-1:0] S24_MAX = 24'sh7FFFFF;
  localparam logic signed [SampleW-1:0] S24_MIN = 24'sh800000;

  localparam logic [LevelW-1:0]  LEVEL_FULL   = 7'd100;
  localparam logic [SampleW-1:0] CEILING_RST  = 24'd8388607;

  localparam logic [CfgIdxW-1:0] CFG_NOISE_FLOOR   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_NOISE_CEILING = 2'd1;

  // Closed-block record handed from the front to the back.
  typedef struct packed {
    logic signed [SampleW-1:0] blk_min;
    logic signed [SampleW-1:0] blk_max;
    logic        [SampleW-1:0] peak;
  } blk_rec_t;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SPAN = 5'b00010,
    ST_MUL  = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_DONE = 5'b10000
  } back_state_e;

endpackage

@@ rtl/abpm_front.sv @@
// Front end: slot to sample conversion and running min/max/peak accumulation.
module abpm_front import abpm_pkg::*; #(
  parameter int unsigned SLOT_SHIFT = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [SlotW-1:0]   slot_word_i,
  input  logic               last_i,
  input  logic               accept_i,
  output logic               push_o,
  output blk_rec_t           rec_o
);

  logic signed [SlotW-1:0]   shifted;
  logic signed [SampleW-1:0] sample;
  logic        [SampleW-1:0] mag;
  logic signed [SampleW-1:0] min_q, min_d, max_q, max_d;
  logic        [SampleW-1:0] peak_q, peak_d;

  assign shifted = $signed(slot_word_i) >>> SLOT_SHIFT;

  // Saturate only matters for shifts below eight
  always_comb begin
    if (shifted > $signed({{(SlotW-SampleW){S24_MAX[SampleW-1]}}, S24_MAX})) begin
      sample = S24_MAX;
    end else if (shifted < $signed({{(SlotW-SampleW){S24_MIN[SampleW-1]}}, S24_MIN})) begin
      sample = S24_MIN;
    end else begin
      sample = shifted[SampleW-1:0];
    end
  end

  // Most negative sample gives 0x800000, kept exactly as unsigned
  assign mag = sample[SampleW-1] ? (~sample + 24'd1) : sample;

  assign min_d  = (sample < min_q) ? sample : min_q;
  assign max_d  = (sample > max_q) ? sample : max_q;
  assign peak_d = (mag > peak_q) ? mag : peak_q;

  assign push_o        = accept_i && last_i;
  assign rec_o.blk_min = min_d;
  assign rec_o.blk_max = max_d;
  assign rec_o.peak    = peak_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q  <= S24_MAX;
      max_q  <= S24_MIN;
      peak_q <= '0;
    end else if (accept_i) begin
      if (last_i) begin
        min_q  <= S24_MAX;
        max_q  <= S24_MIN;
        peak_q <= '0;
      end else begin
        min_q  <= min_d;
        max_q  <= max_d;
        peak_q <= peak_d;
      end
    end
  end

endmodule

@@ rtl/abpm_fifo.sv @@
// Two-entry queue of closed-block records between front and back.
module abpm_fifo import abpm_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  blk_rec_t wdata_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     valid_o,
  output blk_rec_t rdata_o
);

  blk_rec_t   mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q[1];
  assign valid_o = (cnt_q != 2'd0);
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wptr_q <= ~wptr_q;
      end
      if (pop_i) begin
        rptr_q <= ~rptr_q;
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

@@ rtl/abpm_back.sv @@
// Back end: span clamp, x100 scaling and iterative divide to a percent level.
module abpm_back import abpm_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [SampleW-1:0]        noise_floor_i,
  input  logic [SampleW-1:0]        noise_ceiling_i,
  input  logic                      fifo_valid_i,
  input  blk_rec_t                  fifo_data_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic signed [SampleW-1:0] block_min_o,
  output logic signed [SampleW-1:0] block_max_o,
  output logic [SampleW-1:0]        span_o,
  output logic [LevelW-1:0]         level_o
);

  back_state_e        state_q, state_d;
  blk_rec_t           rec_q;
  logic [SampleW-1:0] span_q, span_d;
  logic [ProdW-1:0]   rem_q;
  logic [LevelW-1:0]  quo_q, quo_d, level_q, level_d;
  logic [2:0]         cnt_q;
  logic [SampleW:0]   diff;
  logic [ProdW:0]     dsh, trial;

  // Clamp peak - floor into 0..ceiling
  assign diff = {1'b0, rec_q.peak} - {1'b0, noise_floor_i};
  always_comb begin
    if (diff[SampleW]) begin
      span_d = '0;
    end else if (diff[SampleW-1:0] > noise_ceiling_i) begin
      span_d = noise_ceiling_i;
    end else begin
      span_d = diff[SampleW-1:0];
    end
  end

  // Restoring divide, one quotient bit per cycle; span <= ceiling keeps it below 128
  assign dsh   = {{(ProdW+1-SampleW){1'b0}}, noise_ceiling_i} << cnt_q;
  assign trial = {1'b0, rem_q} - dsh;

  always_comb begin
    quo_d = quo_q;
    quo_d[cnt_q] = ~trial[ProdW];
  end

  always_comb begin
    if (noise_ceiling_i == '0) begin
      level_d = '0;
    end else if ((quo_d == '0) && (span_q != '0)) begin
      level_d = 7'd1;
    end else begin
      level_d = quo_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (fifo_valid_i) state_d = ST_SPAN;
      ST_SPAN: state_d = ST_MUL;
      ST_MUL:  state_d = ST_DIV;
      ST_DIV:  if (cnt_q == 3'd0) state_d = ST_DONE;
      ST_DONE: if (out_ready_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  assign pop_o = (state_q == ST_IDLE) && fifo_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      rec_q <= fifo_data_i;
    end
    if (state_q == ST_SPAN) begin
      span_q <= span_d;
    end
    if (state_q == ST_MUL) begin
      rem_q <= ProdW'(span_q) * ProdW'(LEVEL_FULL);
      quo_q <= '0;
      cnt_q <= 3'(LevelW - 1);
    end
    if (state_q == ST_DIV) begin
      if (!trial[ProdW]) begin
        rem_q <= trial[ProdW-1:0];
      end
      quo_q <= quo_d;
      cnt_q <= cnt_q - 3'd1;
      if (cnt_q == 3'd0) begin
        level_q <= level_d;
      end
    end
  end

  assign out_valid_o = (state_q == ST_DONE);
  assign block_min_o = rec_q.blk_min;
  assign block_max_o = rec_q.blk_max;
  assign span_o      = span_q;
  assign level_o     = level_q;

endmodule

@@ rtl/audio_block_peak_meter.sv @@
// Top level of the audio block peak meter.
//
// Input channel (in_valid_i/in_ready_o) carries one raw 32-bit slot word per
// transaction with last_i marking the final word of a measurement block. Each
// word is shifted by SLOT_SHIFT into a signed 24-bit sample and folded into
// running min, max and peak in the same cycle, so while in_ready_o is high
// words go in at one per cycle. The word marked last closes the block: its
// record goes into a two-entry queue and the accumulators restart.
// The back end takes a record and produces one result transaction
// (block_min_o, block_max_o, span_o, level_o) on out_valid_o/out_ready_i
// once it has dequeued the record, clamped the span, done the x100 multiply
// and run the bit-per-cycle divide by the ceiling. That divide sets the floor
// on block length for sustained one word per cycle.
// A stalled receiver holds the result; the queue then fills and in_ready_o
// drops once two closed blocks are waiting.
// Config writes (cfg_we_i, cfg_idx_i, cfg_wdata_i) are registered; index 0
// is noise floor, 1 is noise ceiling, others are ignored.
// Reset clears the accumulators and queue, floor to 0, ceiling to 8388607.
module audio_block_peak_meter import abpm_pkg::*; #(
  parameter int unsigned SLOT_SHIFT = 8
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [CfgIdxW-1:0]        cfg_idx_i,
  input  logic [SampleW-1:0]        cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic signed [SlotW-1:0]   slot_word_i,
  input  logic                      last_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic signed [SampleW-1:0] block_min_o,
  output logic signed [SampleW-1:0] block_max_o,
  output logic [SampleW-1:0]        span_o,
  output logic [LevelW-1:0]         level_o
);

  logic [SampleW-1:0] noise_floor_q, noise_ceiling_q;
  logic               accept, push, full, pop, fifo_valid;
  blk_rec_t           front_rec, fifo_rec;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      noise_floor_q   <= '0;
      noise_ceiling_q <= CEILING_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_NOISE_FLOOR:   noise_floor_q   <= cfg_wdata_i;
        CFG_NOISE_CEILING: noise_ceiling_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign in_ready_o = ~full;
  assign accept     = in_valid_i && in_ready_o;

  abpm_front #(
    .SLOT_SHIFT (SLOT_SHIFT)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .slot_word_i (slot_word_i),
    .last_i      (last_i),
    .accept_i    (accept),
    .push_o      (push),
    .rec_o       (front_rec)
  );

  abpm_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (front_rec),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (fifo_valid),
    .rdata_o (fifo_rec)
  );

  abpm_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .noise_floor_i   (noise_floor_q),
    .noise_ceiling_i (noise_ceiling_q),
    .fifo_valid_i    (fifo_valid),
    .fifo_data_i     (fifo_rec),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .block_min_o     (block_min_o),
    .block_max_o     (block_max_o),
    .span_o          (span_o),
    .level_o         (level_o)
  );

  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (level_o <= LEVEL_FULL))
    else $error("level above full scale");

  a_level_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((span_o == '0) == (level_o == '0)))
    else $error("level and span disagree on zero");

  a_span_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (span_o <= noise_ceiling_q))
    else $error("span above ceiling");

  a_min_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (block_min_o <= block_max_o))
    else $error("block min above block max");

endmodule

@@ bench/audio_block_peak_meter_test.sv @@
// Self-checking testbench for the audio block peak meter: directed, random and backpressure runs.
module audio_block_peak_meter_test;
  timeunit 1ns;
  timeprecision 1ps;
  import abpm_pkg::*;

  localparam int unsigned SLOT_SHIFT   = 8;
  localparam int          CYCLE_LIMIT  = 400000;
  localparam int          BACK_LATENCY = 10;
  localparam int          RX_HOLD_LEN  = 300;
  localparam int          RAND_PHASES  = 8;
  localparam int          PHASE_WORDS  = 230;
  localparam logic [CfgIdxW-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_SPARE_B = 2'd3;

  typedef struct {
    logic signed [SampleW-1:0] blk_min;
    logic signed [SampleW-1:0] blk_max;
    logic        [SampleW-1:0] span;
    logic        [LevelW-1:0]  level;
  } meter_result_t;

  logic                      clk_i       = 1'b0;
  logic                      rst_ni      = 1'b0;
  logic                      cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]        cfg_idx_i   = '0;
  logic [SampleW-1:0]        cfg_wdata_i = '0;
  logic                      in_valid_i  = 1'b0;
  logic                      in_ready_o;
  logic signed [SlotW-1:0]   slot_word_i = '0;
  logic                      last_i      = 1'b0;
  logic                      out_valid_o;
  logic                      out_ready_i = 1'b0;
  logic signed [SampleW-1:0] block_min_o;
  logic signed [SampleW-1:0] block_max_o;
  logic [SampleW-1:0]        span_o;
  logic [LevelW-1:0]         level_o;

  audio_block_peak_meter #(
    .SLOT_SHIFT(SLOT_SHIFT)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .slot_word_i(slot_word_i),
    .last_i     (last_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .block_min_o(block_min_o),
    .block_max_o(block_max_o),
    .span_o     (span_o),
    .level_o    (level_o)
  );

  always #1 clk_i = ~clk_i;

  // Meter model state
  logic signed [SampleW-1:0] acc_min;
  logic signed [SampleW-1:0] acc_max;
  logic        [SampleW-1:0] acc_peak;
  logic        [SampleW-1:0] floor_reg;
  logic        [SampleW-1:0] ceiling_reg;
  meter_result_t             pending_results[$];

  int mismatch_count = 0;
  int words_sent     = 0;
  int results_seen   = 0;
  int reg_writes     = 0;
  int holdoffs_done  = 0;
  int cycle_count    = 0;
  int burst_left     = 1;

  // Receiver stall pattern state
  int rx_hold_req  = 0;
  int rx_hold_seen = 0;
  int rx_hold_left = 0;
  int rx_mode      = 0;
  int rx_mode_left = 0;
  int rx_phase     = 0;

  function automatic logic signed [SampleW-1:0] word_to_sample(logic signed [SlotW-1:0] word);
    longint v;
    v = longint'(word) >>> SLOT_SHIFT;
    if (v > longint'(S24_MAX)) v = longint'(S24_MAX);
    if (v < longint'(S24_MIN)) v = longint'(S24_MIN);
    return v[SampleW-1:0];
  endfunction

  function automatic void clear_meter();
    acc_min  = S24_MAX;
    acc_max  = S24_MIN;
    acc_peak = '0;
  endfunction

  // Fold one accepted word into the model; a closing word yields a result.
  function automatic void fold_word(logic [SlotW-1:0] word, logic last);
    logic signed [SampleW-1:0] smp;
    longint                    mag;
    longint                    diff;
    longint                    lvl;
    meter_result_t             res;
    smp = word_to_sample(word);
    mag = (smp < 0) ? -longint'(smp) : longint'(smp);
    if (smp < acc_min) acc_min = smp;
    if (smp > acc_max) acc_max = smp;
    if (mag > longint'(acc_peak)) acc_peak = mag[SampleW-1:0];
    if (last) begin
      diff = longint'(acc_peak) - longint'(floor_reg);
      if (diff < 0) diff = 0;
      if (diff > longint'(ceiling_reg)) diff = longint'(ceiling_reg);
      if (ceiling_reg == '0) begin
        lvl = 0;
      end else begin
        lvl = (diff * 100) / longint'(ceiling_reg);
        if (diff > 0 && lvl == 0) lvl = 1;
      end
      res.blk_min = acc_min;
      res.blk_max = acc_max;
      res.span    = diff[SampleW-1:0];
      res.level   = lvl[LevelW-1:0];
      pending_results.push_back(res);
      clear_meter();
    end
  endfunction

  function automatic logic [SlotW-1:0] pick_word();
    logic [SlotW-1:0] w;
    logic [19:0]      mid;
    logic [11:0]      tiny;
    mid  = 20'($urandom);
    tiny = 12'($urandom);
    case ($urandom_range(0, 7))
      0, 1, 2: w = $urandom;
      3:       w = {8'h7F, 24'($urandom)};
      4:       w = {8'h80, 24'($urandom)};
      5:       w = {{12{mid[19]}}, mid};
      6:       w = {{20{tiny[11]}}, tiny};
      default: begin
        case ($urandom_range(0, 5))
          0:       w = 32'h7FFF_FFFF;
          1:       w = 32'h8000_0000;
          2:       w = 32'h0000_0000;
          3:       w = 32'hFFFF_FFFF;
          4:       w = 32'h0000_00FF;
          default: w = 32'hFFFF_FF00;
        endcase
      end
    endcase
    return w;
  endfunction

  // Called at a falling edge; returns at a falling edge with valid possibly still high.
  task automatic offer_word(input logic [SlotW-1:0] word, input logic last);
    int gap;
    in_valid_i  <= 1'b1;
    slot_word_i <= word;
    last_i      <= last;
    do @(posedge clk_i); while (!in_ready_o);
    fold_word(word, last);
    words_sent++;
    @(negedge clk_i);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      gap = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 3) : $urandom_range(4, 20);
      repeat (gap) @(negedge clk_i);
      burst_left = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 8) : $urandom_range(30, 80);
    end
  endtask

  task automatic send_block(input int len);
    for (int i = 0; i < len - 1; i++) offer_word(pick_word(), 1'b0);
    offer_word(pick_word(), 1'b1);
  endtask

  // Stop offering and wait until every result is back and the back end is quiet.
  task automatic drain_meter();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (2 * BACK_LATENCY) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [SampleW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
    case (idx)
      CFG_NOISE_FLOOR:   floor_reg   = data;
      CFG_NOISE_CEILING: ceiling_reg = data;
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic test_reset_defaults();
    // full-scale swing: peak above the ceiling clamps to it
    offer_word(32'h7FFF_FFFF, 1'b0);
    offer_word(32'h8000_0000, 1'b1);
    offer_word(32'h0000_0000, 1'b1);
    offer_word(32'hFFFF_FFFF, 1'b1);
    // tiny span against a large ceiling is raised to level one
    offer_word(32'h0000_1000, 1'b1);
    // most negative sample on its own
    offer_word(32'h8000_00FF, 1'b1);
    offer_word(32'h0000_00FF, 1'b0);
    offer_word(32'hFFFF_FF00, 1'b0);
    offer_word(32'h1234_5678, 1'b1);
    drain_meter();
  endtask

  task automatic test_register_extremes();
    write_reg(CFG_NOISE_CEILING, 24'h80_0000);
    offer_word(32'h8000_0000, 1'b1);
    offer_word(32'h4000_0000, 1'b1);
    drain_meter();
    write_reg(CFG_NOISE_FLOOR, 24'h80_0000);
    offer_word(32'h8000_0000, 1'b1);
    drain_meter();
    // zero ceiling: span clamps to zero and the level is forced to zero
    write_reg(CFG_NOISE_FLOOR, 24'h00_0000);
    write_reg(CFG_NOISE_CEILING, 24'h00_0000);
    offer_word(32'h7FFF_FF00, 1'b1);
    drain_meter();
    write_reg(CFG_NOISE_CEILING, 24'h00_0001);
    offer_word(32'h0000_0100, 1'b1);
    offer_word(32'h0000_0000, 1'b1);
    drain_meter();
    // spare indexes must leave both registers alone
    write_reg(CFG_SPARE_A, 24'hFF_FFFF);
    write_reg(CFG_SPARE_B, 24'hFF_FFFF);
    offer_word(32'hFFFF_FE00, 1'b1);
    drain_meter();
    write_reg(CFG_NOISE_FLOOR, 24'hFF_FFFF);
    write_reg(CFG_NOISE_CEILING, 24'hFF_FFFF);
    offer_word(32'h7FFF_FFFF, 1'b1);
    drain_meter();
    write_reg(CFG_NOISE_FLOOR, 24'h12_3456);
    write_reg(CFG_NOISE_CEILING, 24'h65_4321);
    offer_word(32'h4000_0000, 1'b0);
    offer_word(32'hC000_0000, 1'b1);
    drain_meter();
  endtask

  task automatic test_random_phases();
    logic [SampleW-1:0] fl;
    logic [SampleW-1:0] cl;
    int                 target;
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case ($urandom_range(0, 4))
        0:       fl = '0;
        1:       fl = 24'h80_0000;
        2:       fl = SampleW'($urandom_range(0, 24'h1000));
        3:       fl = SampleW'($urandom);
        default: fl = SampleW'($urandom_range(24'h20_0000, 24'h60_0000));
      endcase
      case ($urandom_range(0, 6))
        0:       cl = 24'h00_0001;
        1:       cl = 24'h80_0000;
        2:       cl = '0;
        3:       cl = SampleW'($urandom);
        4:       cl = 24'h7F_FFFF;
        default: cl = SampleW'($urandom_range(1, 24'h2000));
      endcase
      write_reg(CFG_NOISE_FLOOR, fl);
      write_reg(CFG_NOISE_CEILING, cl);
      if ($urandom_range(0, 1)) write_reg(CfgIdxW'($urandom_range(2, 3)), SampleW'($urandom));
      target = words_sent + PHASE_WORDS;
      while (words_sent < target)
        send_block(($urandom_range(0, 9) < 8) ? $urandom_range(1, 12) : $urandom_range(13, 90));
      drain_meter();
    end
  endtask

  task automatic test_rx_holdoff();
    write_reg(CFG_NOISE_FLOOR, SampleW'($urandom_range(0, 24'h1000)));
    write_reg(CFG_NOISE_CEILING, 24'h7F_FFFF);
    rx_hold_req <= rx_hold_req + 1;
    @(negedge clk_i);
    // short blocks back up the record queue until the input stalls
    burst_left = 200;
    for (int i = 0; i < 30; i++) send_block($urandom_range(1, 2));
    holdoffs_done++;
    drain_meter();
  endtask

  always @(negedge clk_i) begin
    if (rx_hold_req != rx_hold_seen) begin
      rx_hold_seen = rx_hold_req;
      rx_hold_left = RX_HOLD_LEN;
    end
    if (rx_mode_left == 0) begin
      rx_mode      = $urandom_range(0, 3);
      rx_mode_left = $urandom_range(20, 200);
    end
    rx_mode_left--;
    rx_phase++;
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      case (rx_mode)
        0:       out_ready_i <= 1'b1;
        1:       out_ready_i <= 1'($urandom_range(0, 1));
        2:       out_ready_i <= ($urandom_range(0, 4) != 0);
        default: out_ready_i <= ((rx_phase % 7) < 4);
      endcase
    end
  end

  always @(posedge clk_i) begin : result_check
    meter_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: min %0d max %0d span %0d level %0d",
               block_min_o, block_max_o, span_o, level_o);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        results_seen++;
        if (block_min_o !== want.blk_min) begin
          $error("block_min: expected %0d, got %0d", want.blk_min, block_min_o);
          mismatch_count++;
        end
        if (block_max_o !== want.blk_max) begin
          $error("block_max: expected %0d, got %0d", want.blk_max, block_max_o);
          mismatch_count++;
        end
        if (span_o !== want.span) begin
          $error("span: expected %0d, got %0d", want.span, span_o);
          mismatch_count++;
        end
        if (level_o !== want.level) begin
          $error("level: expected %0d, got %0d", want.level, level_o);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("run stopped after %0d cycles, %0d results outstanding",
               cycle_count, pending_results.size());
      $display("[audio_block_peak_meter] ERROR");
      $finish;
    end
  end

  initial begin
    floor_reg   = '0;
    ceiling_reg = CEILING_RST;
    clear_meter();
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_reset_defaults();
    test_register_extremes();
    test_rx_holdoff();
    test_random_phases();

    drain_meter();
    $display("%0d words in, %0d blocks checked, %0d register writes, %0d mismatches",
             words_sent, results_seen, reg_writes, mismatch_count);
    $display("covered full-scale and zero ceilings, spare indexes, %0d long output hold-offs",
             holdoffs_done);
    if (mismatch_count == 0) begin
      $display("[audio_block_peak_meter] OK");
    end else begin
      $display("[audio_block_peak_meter] ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/abpm_pkg.sv
rtl/abpm_front.sv
rtl/abpm_fifo.sv
rtl/abpm_back.sv
rtl/audio_block_peak_meter.sv
bench/audio_block_peak_meter_test.sv
